@@ hdl/hpa_pkg.sv @@
package hpa_pkg;

    localparam int HANDLE_W   = 8;
    localparam int HANDLE_NUM = 1 << HANDLE_W;
    localparam int COUNT_W    = HANDLE_W + 1;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int POOL_SIZE_DEFAULT = 256;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRY     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_RELEASED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/hpa_ctrl.sv @@
module hpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  hpa_pkg::dp_status_t dp_sts,
    output hpa_pkg::ctl_cmd_t  ctl_cmd
);

    hpa_pkg::state_t state_reg;
    hpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hpa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = hpa_pkg::ST_LOOKUP;
                end
            end
            hpa_pkg::ST_LOOKUP: begin
                if (dp_sts.out_free) begin
                    state_next = hpa_pkg::ST_IDLE;
                end
            end
            default: state_next = hpa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        ctl_cmd.load   = 1'b0;
        ctl_cmd.commit = 1'b0;
        unique case (state_reg)
            hpa_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                ctl_cmd.load = s_tvalid;
            end
            hpa_pkg::ST_LOOKUP: begin
                ctl_cmd.commit = dp_sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/hpa_dpath.sv @@
module hpa_dpath #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hpa_pkg::CMD_W-1:0]     s_cmd,
    input  logic [hpa_pkg::HANDLE_W-1:0]  s_handle,
    input  hpa_pkg::ctl_cmd_t             ctl_cmd,
    output hpa_pkg::dp_status_t           dp_sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hpa_pkg::HANDLE_W-1:0]  m_granted,
    output logic [hpa_pkg::STATUS_W-1:0]  m_status
);

    localparam int LIMIT_INT = (POOL_SIZE < hpa_pkg::HANDLE_NUM) ? POOL_SIZE
                                                                  : hpa_pkg::HANDLE_NUM;
    localparam logic [hpa_pkg::COUNT_W-1:0] POOL_LIMIT = hpa_pkg::COUNT_W'(LIMIT_INT);

    logic                          busy_mem [hpa_pkg::HANDLE_NUM];
    logic [hpa_pkg::HANDLE_NUM-1:0] busy_vld_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  queue_mem [hpa_pkg::HANDLE_NUM];

    logic [hpa_pkg::CMD_W-1:0]     cmd_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  handle_reg;
    logic                          busy_rd_reg;
    logic                          vld_rd_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  queue_rd_reg;

    logic [hpa_pkg::HANDLE_W-1:0]  head_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  head_next;
    logic [hpa_pkg::HANDLE_W-1:0]  tail_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  tail_next;
    logic [hpa_pkg::COUNT_W-1:0]   count_reg;
    logic [hpa_pkg::COUNT_W-1:0]   count_next;
    logic [hpa_pkg::COUNT_W-1:0]   fresh_reg;
    logic [hpa_pkg::COUNT_W-1:0]   fresh_next;

    logic                          m_tvalid_reg;
    logic [hpa_pkg::HANDLE_W-1:0]  granted_reg;
    logic [hpa_pkg::STATUS_W-1:0]  status_reg;

    logic                          busy_we;
    logic [hpa_pkg::HANDLE_W-1:0]  busy_waddr;
    logic                          busy_wdata;
    logic                          queue_we;
    logic [hpa_pkg::HANDLE_W-1:0]  granted_next;
    logic [hpa_pkg::STATUS_W-1:0]  status_next;
    logic                          queue_nonempty;
    logic                          handle_busy;

    assign queue_nonempty = (count_reg != '0);
    assign handle_busy    = vld_rd_reg & busy_rd_reg
                            & ({1'b0, handle_reg} < POOL_LIMIT);

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        busy_we      = 1'b0;
        busy_waddr   = handle_reg;
        busy_wdata   = 1'b0;
        queue_we     = 1'b0;
        granted_next = '0;
        status_next  = hpa_pkg::STATUS_OK;
        case (cmd_reg) inside
            hpa_pkg::CMD_ALLOC, hpa_pkg::CMD_TRY: begin
                if (queue_nonempty) begin
                    granted_next = queue_rd_reg;
                    busy_we      = 1'b1;
                    busy_waddr   = queue_rd_reg;
                    busy_wdata   = 1'b1;
                    head_next    = head_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                end else if (cmd_reg == hpa_pkg::CMD_TRY) begin
                    status_next = hpa_pkg::STATUS_NO_RELEASED;
                end else if (fresh_reg < POOL_LIMIT) begin
                    granted_next = fresh_reg[hpa_pkg::HANDLE_W-1:0];
                    busy_we      = 1'b1;
                    busy_waddr   = fresh_reg[hpa_pkg::HANDLE_W-1:0];
                    busy_wdata   = 1'b1;
                    fresh_next   = fresh_reg + 1'b1;
                end else begin
                    status_next = hpa_pkg::STATUS_EXHAUSTED;
                end
            end
            hpa_pkg::CMD_RELEASE: begin
                if (handle_busy) begin
                    busy_we    = 1'b1;
                    busy_waddr = handle_reg;
                    busy_wdata = 1'b0;
                    queue_we   = 1'b1;
                    tail_next  = tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    status_next = hpa_pkg::STATUS_BAD_RELEASE;
                end
            end
            default: begin
                status_next = hpa_pkg::STATUS_BAD_RELEASE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.load) begin
            cmd_reg      <= s_cmd;
            handle_reg   <= s_handle;
            busy_rd_reg  <= busy_mem[s_handle];
            vld_rd_reg   <= busy_vld_reg[s_handle];
            queue_rd_reg <= queue_mem[head_reg];
        end
        if (ctl_cmd.commit && busy_we) begin
            busy_mem[busy_waddr] <= busy_wdata;
        end
        if (ctl_cmd.commit && queue_we) begin
            queue_mem[tail_reg] <= handle_reg;
        end
        if (ctl_cmd.commit) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_vld_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctl_cmd.commit) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                fresh_reg <= fresh_next;
                if (busy_we) begin
                    busy_vld_reg[busy_waddr] <= 1'b1;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign dp_sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_granted       = granted_reg;
    assign m_status        = status_reg;

endmodule

@@ hdl/handle_pool_allocator_unit.sv @@
// Channel | Dir | Ports                    | Payload
// s_      | in  | s_tvalid/s_tready/s_tdata | s_tdata[7:0] handle, s_tuser[1:0] cmd
// m_      | out | m_tvalid/m_tready/m_tdata | m_tdata[7:0] granted_handle, m_tuser[1:0] status
//
// Each request reads the busy map and free queue memories in IDLE, then LOOKUP decides and
// writes the busy map (and the free queue on a release) back; the next is taken after that.
// A result waits in the output register while the next request is accepted and read;
// its write-back holds until the output register is free.
// aresetn is synchronous and clears the busy map valid bits, queue pointers and fresh counter.
module handle_pool_allocator_unit #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] handle
    input  logic [hpa_pkg::CMD_W-1:0]     s_tuser,  // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [7:0] granted_handle
    output logic [hpa_pkg::STATUS_W-1:0]  m_tuser   // [1:0] status
);

    hpa_pkg::ctl_cmd_t   ctl_cmd;
    hpa_pkg::dp_status_t dp_sts;

    hpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_sts   (dp_sts),
        .ctl_cmd  (ctl_cmd)
    );

    hpa_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_cmd     (s_tuser),
        .s_handle  (s_tdata),
        .ctl_cmd   (ctl_cmd),
        .dp_sts    (dp_sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_granted (m_tdata),
        .m_status  (m_tuser)
    );

endmodule

@@ tb/sv/handle_pool_allocator_checker.sv @@
`timescale 1ns / 100ps

module handle_pool_allocator_checker #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] handle
    input  logic [hpa_pkg::CMD_W-1:0]    s_tuser,  // [1:0] cmd
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [7:0]                   m_tdata,  // [7:0] granted_handle
    input  logic [hpa_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
    output int                           fail_count,
    output int                           pending
);

    localparam int POOL_LIMIT = (POOL_SIZE < hpa_pkg::HANDLE_NUM) ? POOL_SIZE
                                                                   : hpa_pkg::HANDLE_NUM;

    typedef struct packed {
        logic [hpa_pkg::HANDLE_W-1:0] granted;
        logic [hpa_pkg::STATUS_W-1:0] status;
    } grant_t;

    bit                           pool_busy     [hpa_pkg::HANDLE_NUM];
    logic [hpa_pkg::HANDLE_W-1:0] released_fifo [hpa_pkg::HANDLE_NUM];
    logic [hpa_pkg::HANDLE_W-1:0] rel_head;
    logic [hpa_pkg::HANDLE_W-1:0] rel_tail;
    logic [hpa_pkg::COUNT_W-1:0]  rel_count;
    logic [hpa_pkg::COUNT_W-1:0]  fresh_next;
    grant_t                       grant_q [$];
    int                           errors = 0;

    function automatic logic [hpa_pkg::HANDLE_W-1:0] take_released();
        logic [hpa_pkg::HANDLE_W-1:0] h;
        h         = released_fifo[rel_head];
        rel_head  = rel_head + 1'b1;
        rel_count = rel_count - 1'b1;
        pool_busy[h] = 1'b1;
        return h;
    endfunction

    function automatic grant_t predict_grant(logic [hpa_pkg::CMD_W-1:0] cmd,
                                             logic [hpa_pkg::HANDLE_W-1:0] h);
        grant_t g;
        g.granted = '0;
        g.status  = hpa_pkg::STATUS_OK;
        case (cmd)
            hpa_pkg::CMD_ALLOC: begin
                if (rel_count != 0) begin
                    g.granted = take_released();
                end else if (fresh_next < POOL_LIMIT) begin
                    g.granted = fresh_next[hpa_pkg::HANDLE_W-1:0];
                    pool_busy[g.granted] = 1'b1;
                    fresh_next = fresh_next + 1'b1;
                end else begin
                    g.status = hpa_pkg::STATUS_EXHAUSTED;
                end
            end
            hpa_pkg::CMD_TRY: begin
                if (rel_count != 0) begin
                    g.granted = take_released();
                end else begin
                    g.status = hpa_pkg::STATUS_NO_RELEASED;
                end
            end
            hpa_pkg::CMD_RELEASE: begin
                if (h >= POOL_LIMIT || !pool_busy[h]) begin
                    g.status = hpa_pkg::STATUS_BAD_RELEASE;
                end else begin
                    pool_busy[h] = 1'b0;
                    released_fifo[rel_tail] = h;
                    rel_tail  = rel_tail + 1'b1;
                    rel_count = rel_count + 1'b1;
                end
            end
            default: begin
                g.status = hpa_pkg::STATUS_BAD_RELEASE;
            end
        endcase
        return g;
    endfunction

    always @(posedge aclk) begin : watch
        grant_t want;
        if (!aresetn) begin
            foreach (pool_busy[i]) pool_busy[i] = 1'b0;
            rel_head   = '0;
            rel_tail   = '0;
            rel_count  = '0;
            fresh_next = '0;
            grant_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected result beat: granted_handle %0d, status %0d",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata !== want.granted) begin
                        $error("granted_handle: expected %0d, actual %0d",
                               want.granted, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                grant_q.push_back(predict_grant(s_tuser, s_tdata));
            end
        end
        fail_count <= errors;
        pending    <= grant_q.size();
    end

endmodule

@@ tb/sv/handle_pool_allocator_unit_test.sv @@
`timescale 1ns / 100ps

module handle_pool_allocator_unit_test;

    localparam logic [hpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata  = '0;
    logic [hpa_pkg::CMD_W-1:0]    s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [7:0]                   m_tdata;
    logic [hpa_pkg::STATUS_W-1:0] m_tuser;
    int                           fail_count;
    int                           pending;
    int                           cycle_count = 0;
    bit                           tx_idle_on  = 1'b1;
    bit                           rx_idle_on  = 1'b1;
    int                           long_hold_req = 0;

    handle_pool_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    handle_pool_allocator_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin : result_sink
        int rx_hold;
        int hold_seen;
        rx_hold   = 0;
        hold_seen = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (long_hold_req != hold_seen) begin
                hold_seen = long_hold_req;
                rx_hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                rx_hold = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_req(input logic [hpa_pkg::CMD_W-1:0] cmd, input logic [7:0] h);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= h;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_mixed(input int n, input int alloc_pct, input int rel_pct,
                              input int try_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                send_req(hpa_pkg::CMD_ALLOC, 8'($urandom));
            else if (r < alloc_pct + rel_pct)
                send_req(hpa_pkg::CMD_RELEASE, 8'($urandom));
            else if (r < alloc_pct + rel_pct + try_pct)
                send_req(hpa_pkg::CMD_TRY, 8'($urandom));
            else
                send_req(CMD_UNUSED, 8'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [7:0] order [256];
        logic [7:0] tmp;
        int j;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pool, bad releases, unused command
        send_req(hpa_pkg::CMD_TRY, 8'h5A);
        send_req(hpa_pkg::CMD_RELEASE, 8'h00);
        send_req(hpa_pkg::CMD_RELEASE, 8'hFF);
        send_req(CMD_UNUSED, 8'hA5);
        send_req(hpa_pkg::CMD_ALLOC, 8'hFF);
        send_req(hpa_pkg::CMD_ALLOC, 8'h00);
        send_req(hpa_pkg::CMD_ALLOC, 8'($urandom));
        send_req(hpa_pkg::CMD_RELEASE, 8'd1);
        send_req(hpa_pkg::CMD_RELEASE, 8'd1);
        send_req(hpa_pkg::CMD_ALLOC, 8'h00);
        send_req(hpa_pkg::CMD_RELEASE, 8'd0);
        send_req(hpa_pkg::CMD_RELEASE, 8'd2);
        send_req(hpa_pkg::CMD_TRY, 8'hFF);
        send_req(hpa_pkg::CMD_ALLOC, 8'h00);
        send_req(hpa_pkg::CMD_TRY, 8'h00);
        send_req(hpa_pkg::CMD_ALLOC, 8'h00);
        send_req(hpa_pkg::CMD_RELEASE, 8'd3);
        send_req(hpa_pkg::CMD_RELEASE, 8'd1);
        send_req(CMD_UNUSED, 8'h00);
        send_req(hpa_pkg::CMD_TRY, 8'h00);
        send_req(hpa_pkg::CMD_TRY, 8'h00);
        send_req(hpa_pkg::CMD_RELEASE, 8'h80);

        // grow the pool, then run it dry
        send_mixed(200, 75, 12, 8);
        repeat (280) send_req(hpa_pkg::CMD_ALLOC, 8'($urandom));
        wait_drained();

        // churn against a stalled result side
        long_hold_req++;
        send_mixed(150, 30, 45, 20);

        // hand out everything, release all, reclaim all
        repeat (280) send_req(hpa_pkg::CMD_ALLOC, 8'($urandom));
        for (int i = 0; i < 256; i++) order[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 256; i++) send_req(hpa_pkg::CMD_RELEASE, order[i]);
        repeat (260) send_req(hpa_pkg::CMD_TRY, 8'($urandom));

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_mixed(150, 35, 40, 20);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
